// ----- rtl/sconv_pkg.sv -----
package sconv_pkg;

  localparam int TAPS = 11;
  localparam int HALF = TAPS / 2;
  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int CFG_W = 9;
  localparam int PIX_W = 8;
  localparam int ROW_W = 21;
  localparam int OUT_W = 32;
  localparam int TAP_W = 4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  function automatic logic [9:0] tap_weight(input logic [TAP_W-1:0] k);
    unique case (k)
      4'd0, 4'd10: tap_weight = 10'd36;
      4'd1, 4'd9:  tap_weight = 10'd111;
      4'd2, 4'd8:  tap_weight = 10'd266;
      4'd3, 4'd7:  tap_weight = 10'd498;
      4'd4, 4'd6:  tap_weight = 10'd724;
      4'd5:        tap_weight = 10'd821;
      default:     tap_weight = 10'd0;
    endcase
  endfunction

  // controller to datapath
  typedef struct packed {
    logic store_pixel;   // write pixel at load position
    logic row_clear;     // start a row-pass sum
    logic row_tap;       // issue one row-pass read
    logic row_write;     // write row-pass result
    logic col_clear;     // start a column sum
    logic col_tap;       // issue one column read
    logic out_load;      // capture result into output register
    logic out_incomplete;
    logic load_adv;
    logic emit_adv;
    logic frame_restart;
    logic [TAP_W-1:0] tap;
  } sconv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_done;   // current load position is the last pixel of a row
    logic frame_full; // load position reached total
    logic col_last;   // row-pass column sweep at its end
    logic last_pos;   // emit position is the final pixel
  } sconv_sts_t;

endpackage

// ----- rtl/sconv_ram.sv -----
module sconv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/sconv_ctrl.sv -----
module sconv_ctrl import sconv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       cfg_hit,
  input  sconv_sts_t sts,
  output sconv_cmd_t cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROWS  = 6'b000010,
    S_ROWT  = 6'b000100,
    S_ROWW  = 6'b001000,
    S_COLT  = 6'b010000,
    S_COLW  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [TAP_W-1:0] tap, tap_next;
  logic accept;

  // read, operand and product registers lie between tap issue and accumulate
  localparam int LAT = 3;
  localparam logic [TAP_W-1:0] TAP_END = TAP_W'(TAPS + LAT - 1);

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    tap_next = tap;
    cmd = '0;
    cmd.tap = tap;
    unique case (state)
      S_IDLE: begin
        if (cfg_hit) begin
          cmd.frame_restart = 1'b1;
        end else if (accept && command == CMD_LOAD) begin
          if (!sts.frame_full) begin
            cmd.store_pixel = 1'b1;
            cmd.load_adv = 1'b1;
            if (sts.row_done) begin
              state_next = S_ROWS;
            end
          end
        end else if (accept) begin
          if (!sts.frame_full) begin
            cmd.out_load = 1'b1;
            cmd.out_incomplete = 1'b1;
          end else begin
            cmd.col_clear = 1'b1;
            tap_next = '0;
            state_next = S_COLT;
          end
        end
      end
      S_ROWS: begin
        cmd.row_clear = 1'b1;
        tap_next = '0;
        state_next = S_ROWT;
      end
      S_ROWT: begin
        cmd.row_tap = 1'b1;
        tap_next = tap + 1'b1;
        if (tap == TAP_END) begin
          state_next = S_ROWW;
        end
      end
      S_ROWW: begin
        cmd.row_write = 1'b1;
        if (sts.col_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.row_clear = 1'b1;
          tap_next = '0;
          state_next = S_ROWT;
        end
      end
      S_COLT: begin
        cmd.col_tap = 1'b1;
        tap_next = tap + 1'b1;
        if (tap == TAP_END) begin
          state_next = S_COLW;
        end
      end
      S_COLW: begin
        cmd.out_load = 1'b1;
        cmd.emit_adv = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap <= '0;
    end else begin
      state <= state_next;
      tap <= tap_next;
    end
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("request taken while busy");
  a_colw_from_colt: assert property (@(posedge clk) disable iff (rst)
    state == S_COLW |-> $past(state) == S_COLT) else $error("bad column sequence");
  a_roww_from_rowt: assert property (@(posedge clk) disable iff (rst)
    state == S_ROWW |-> $past(state) == S_ROWT) else $error("bad row sequence");
endmodule

// ----- rtl/sconv_dp.sv -----
module sconv_dp import sconv_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] width_cfg,
  input  logic [CFG_W-1:0] height_cfg,
  input  logic [PIX_W-1:0] pixel_value,
  input  sconv_cmd_t       cmd,
  output sconv_sts_t       sts,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [OUT_W-1:0] filtered_value,
  output logic             frame_end,
  output logic             frame_incomplete
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  // effective dimensions, saturated
  logic [DW-1:0] w;
  logic [HW-1:0] h;
  always_comb begin
    if (32'(width_cfg) < 32'(TAPS)) w = DW'(TAPS);
    else if (32'(width_cfg) > 32'(MAX_WIDTH)) w = DW'(MAX_WIDTH);
    else w = DW'(width_cfg);
    if (32'(height_cfg) < 32'(TAPS)) h = HW'(TAPS);
    else if (32'(height_cfg) > 32'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else h = HW'(height_cfg);
  end

  // positions tracked as row/column counters plus linear address
  logic [PW-1:0] load_pos;
  logic [DW-1:0] load_col;
  logic [HW-1:0] emit_row;
  logic [DW-1:0] emit_col;
  logic [PW-1:0] emit_pos;
  logic [PW-1:0] total;
  logic [DW-1:0] rp_col;     // row-pass column under work
  logic [PW-1:0] rp_addr;    // row start + rp_col

  always_ff @(posedge clk) begin
    total <= PW'(w * h);
  end

  assign sts.frame_full = load_pos >= total;
  assign sts.row_done = load_col == w - 1'b1;
  assign sts.col_last = rp_col == w - DW'(HALF + 1);
  assign sts.last_pos = emit_pos == total - 1'b1;

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_restart || (cmd.emit_adv && sts.last_pos)) begin
      load_pos <= '0;
      load_col <= '0;
      emit_row <= '0;
      emit_col <= '0;
      emit_pos <= '0;
    end else begin
      if (cmd.load_adv) begin
        load_pos <= load_pos + 1'b1;
        if (sts.row_done) begin
          load_col <= '0;
        end else begin
          load_col <= load_col + 1'b1;
        end
      end
      if (cmd.emit_adv) begin
        emit_pos <= emit_pos + 1'b1;
        if (emit_col == w - 1'b1) begin
          emit_col <= '0;
          emit_row <= emit_row + 1'b1;
        end else begin
          emit_col <= emit_col + 1'b1;
        end
      end
    end
  end

  // start of the row just completed, fixed for the whole sweep
  logic [PW-1:0] sweep_base;
  always_ff @(posedge clk) begin
    if (cmd.load_adv && sts.row_done) begin
      sweep_base <= load_pos + 1'b1 - PW'(w);
      rp_col <= DW'(HALF);
    end else if (cmd.row_write) begin
      rp_col <= rp_col + 1'b1;
    end
  end
  assign rp_addr = sweep_base + PW'(rp_col);

  // clamped centre for column pass
  logic [HW-1:0] rr;
  logic [DW-1:0] cc;
  always_comb begin
    if (emit_row < HW'(HALF)) rr = HW'(HALF);
    else if (emit_row > h - HW'(HALF + 1)) rr = h - HW'(HALF + 1);
    else rr = emit_row;
    if (emit_col < DW'(HALF)) cc = DW'(HALF);
    else if (emit_col > w - DW'(HALF + 1)) cc = w - DW'(HALF + 1);
    else cc = emit_col;
  end

  // column tap address: (rr - HALF + tap) * w + cc, built by stepping
  logic [PW-1:0] col_addr;
  logic [PW-1:0] col_start;
  always_ff @(posedge clk) begin
    col_start <= PW'((rr - HW'(HALF)) * w) + PW'(cc);
  end
  always_ff @(posedge clk) begin
    if (cmd.col_clear) begin
      col_addr <= '0;
    end else if (cmd.col_tap) begin
      col_addr <= col_addr + PW'(w);
    end
  end

  // memories
  logic [PIX_W-1:0] pix_rd;
  logic [ROW_W-1:0] row_rd;
  logic [AW-1:0] pix_waddr, pix_raddr;
  logic [ROW_W-1:0] row_sum;

  assign pix_waddr = load_pos[AW-1:0];
  assign pix_raddr = AW'(rp_addr - PW'(HALF) + PW'(cmd.tap));

  sconv_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_pix (
    .clk(clk), .we(cmd.store_pixel), .waddr(pix_waddr), .wdata(pixel_value),
    .raddr(pix_raddr), .rdata(pix_rd)
  );

  sconv_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_row (
    .clk(clk), .we(cmd.row_write), .waddr(rp_addr[AW-1:0]), .wdata(row_sum),
    .raddr(AW'(col_start + col_addr)), .rdata(row_rd)
  );

  // tap index delayed to match registered read
  logic [TAP_W-1:0] tap_d1, tap_d2;
  logic row_v1, row_v2, col_v1, col_v2;
  logic [9:0] wgt;
  logic [PIX_W-1:0] pix_q;
  logic [ROW_W-1:0] row_q;
  logic [ROW_W+9:0] prod_c;
  logic [PIX_W+9:0] prod_r;
  logic prod_rv, prod_cv;
  logic [OUT_W-1:0] col_sum;

  always_ff @(posedge clk) begin
    tap_d1 <= cmd.tap;
    row_v1 <= cmd.row_tap && cmd.tap < TAP_W'(TAPS);
    col_v1 <= cmd.col_tap && cmd.tap < TAP_W'(TAPS);
    tap_d2 <= tap_d1;
    row_v2 <= row_v1;
    col_v2 <= col_v1;
    pix_q <= pix_rd;
    row_q <= row_rd;
    prod_r <= pix_q * wgt;
    prod_c <= row_q * wgt;
    prod_rv <= row_v2;
    prod_cv <= col_v2;
  end
  assign wgt = tap_weight(tap_d2);

  // tap counter starts reading at tap 0 so issue is one ahead of LAT-1 stages
  always_ff @(posedge clk) begin
    if (cmd.row_clear) begin
      row_sum <= '0;
    end else if (prod_rv) begin
      row_sum <= row_sum + ROW_W'(prod_r);
    end
    if (cmd.col_clear) begin
      col_sum <= '0;
    end else if (prod_cv) begin
      col_sum <= col_sum + OUT_W'(prod_c);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered_value <= cmd.out_incomplete ? '0 : col_sum;
      frame_incomplete <= cmd.out_incomplete;
      frame_end <= !cmd.out_incomplete && sts.last_pos;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    prod_cv |-> $past(col_v1, 2)) else $error("column pipe skew");
endmodule

// ----- rtl/separable_conv11_edge_clamp.sv -----
// separable 11-tap smoothing filter with edge clamp
// input channel: in_valid / in_stall with command and pixel_value.
//   command 0 loads the next pixel of the frame in raster order; command 1
//   fetches the next filtered pixel in raster order.
// output channel: out_valid / out_stall with filtered_value, frame_end and
//   frame_incomplete; one result per fetch request, none per load.
// a load that ends a row starts a horizontal sweep over the row, with eleven
//   weighted reads of the pixel memory per column plus the read and multiply
//   pipeline, during which requests stall.
// a fetch on a full frame makes eleven reads of the row-pass memory through
//   its single read port, then drains the pipeline.
// a fetch before the frame is fully loaded returns zero with frame_incomplete
//   in the next cycle.
// the last pixel of the frame sets frame_end and restarts loading.
// a register write restarts the frame; dimensions saturate to 11..max.
// reset clears positions and sets both dimensions to 256; memory contents
//   are left as they are and are only read after being written.
// while the receiver stalls, the result holds and new requests stall.
module separable_conv11_edge_clamp import sconv_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             command,
  input  logic [PIX_W-1:0] pixel_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] filtered_value,
  output logic             frame_end,
  output logic             frame_incomplete,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  logic [CFG_W-1:0] image_width, image_height;
  sconv_cmd_t cmd;
  sconv_sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= CFG_W'(256);
      image_height <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  sconv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .out_valid(out_valid), .out_stall(out_stall),
    .cfg_hit(cfg_we), .sts(sts), .cmd(cmd)
  );

  sconv_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk(clk), .rst(rst), .width_cfg(image_width), .height_cfg(image_height),
    .pixel_value(pixel_value), .cmd(cmd), .sts(sts), .out_stall(out_stall),
    .out_valid(out_valid), .filtered_value(filtered_value),
    .frame_end(frame_end), .frame_incomplete(frame_incomplete)
  );

  a_inc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_incomplete |-> filtered_value == '0 && !frame_end)
    else $error("incomplete result carries data");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid && out_stall) |-> out_valid && $stable(filtered_value))
    else $error("stalled result changed");
endmodule

// ----- dv/separable_conv11_edge_clamp_test.sv -----
module separable_conv11_edge_clamp_test;
  import sconv_pkg::*;

  // cycle budget: a few small frames with row sweeps and settle waits, with margin
  localparam int unsigned CYCLE_LIMIT = 400000;
  // longest row sweep the block can still be busy with after its last result
  localparam int unsigned SETTLE_CYCLES = 5000;
  localparam int unsigned STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic             last;
    logic             incomplete;
  } pixel_result_t;

  // predicts filtered pixels and checks them in order
  class conv_scoreboard;
    localparam int unsigned COEF [TAPS] =
      '{36, 111, 266, 498, 724, 821, 724, 498, 266, 111, 36};

    logic [PIX_W-1:0] image_mem [STORE_DEPTH];
    logic [ROW_W-1:0] row_sums [STORE_DEPTH];
    logic [CFG_W-1:0] width_reg, height_reg;
    int unsigned      loaded, emitted;
    pixel_result_t    pending_pixels [$];
    int unsigned      errors, results, frames, early_fetches;

    function new();
      width_reg = CFG_W'(DEF_MAX_WIDTH);
      height_reg = CFG_W'(DEF_MAX_HEIGHT);
      loaded = 0;
      emitted = 0;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi_lim);
      if (v < TAPS) return TAPS;
      if (v > hi_lim) return hi_lim;
      return v;
    endfunction

    function int unsigned cols();
      return fit(width_reg, DEF_MAX_WIDTH);
    endfunction

    function int unsigned rows();
      return fit(height_reg, DEF_MAX_HEIGHT);
    endfunction

    function void set_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_WIDTH) width_reg = val;
      else height_reg = val;
      loaded = 0;
      emitted = 0;
    endfunction

    // horizontal pass over one completed row, interior columns only
    function void sweep_row(int unsigned r, int unsigned w);
      int unsigned base, acc;
      base = r * w;
      for (int unsigned c = HALF; c < w - HALF; c++) begin
        acc = 0;
        for (int unsigned k = 0; k < TAPS; k++)
          acc += image_mem[(base + c + k - HALF) % STORE_DEPTH] * COEF[k];
        row_sums[(base + c) % STORE_DEPTH] = ROW_W'(acc);
      end
    endfunction

    // vertical pass with the position clamped into the interior
    function logic [OUT_W-1:0] filter_at(int unsigned r, int unsigned c,
                                         int unsigned w, int unsigned h);
      int unsigned rr, cc;
      logic [OUT_W-1:0] acc;
      rr = (r < HALF) ? HALF : (r > h - HALF - 1) ? h - HALF - 1 : r;
      cc = (c < HALF) ? HALF : (c > w - HALF - 1) ? w - HALF - 1 : c;
      acc = 0;
      for (int unsigned k = 0; k < TAPS; k++)
        acc += OUT_W'(row_sums[((rr + k - HALF) * w + cc) % STORE_DEPTH]) * COEF[k];
      return acc;
    endfunction

    function void note_request(logic cmd, logic [PIX_W-1:0] pix);
      int unsigned w, h, total, pos;
      pixel_result_t r;
      w = cols();
      h = rows();
      total = w * h;
      if (cmd == CMD_LOAD) begin
        if (loaded < total) begin
          image_mem[loaded % STORE_DEPTH] = pix;
          if (loaded % w == w - 1) sweep_row(loaded / w, w);
          loaded++;
        end
        return;
      end
      if (loaded < total) begin
        r = '{value: '0, last: 1'b0, incomplete: 1'b1};
        early_fetches++;
      end else begin
        pos = (emitted >= total) ? total - 1 : emitted;
        r.value = filter_at(pos / w, pos % w, w, h);
        r.incomplete = 1'b0;
        r.last = (pos == total - 1);
        if (r.last) begin
          emitted = 0;
          loaded = 0;
          frames++;
        end else begin
          emitted = pos + 1;
        end
      end
      pending_pixels.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [OUT_W-1:0] val, logic fe, logic fi);
      pixel_result_t e;
      results++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected result value=%0d", val));
        return;
      end
      e = pending_pixels.pop_front();
      if (val !== e.value)
        report($sformatf("result %0d value %0d, want %0d", results, val, e.value));
      if (fe !== e.last)
        report($sformatf("result %0d frame_end %b, want %b", results, fe, e.last));
      if (fi !== e.incomplete)
        report($sformatf("result %0d frame_incomplete %b, want %b", results, fi,
                         e.incomplete));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             command = CMD_LOAD;
  logic [PIX_W-1:0] pixel_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] filtered_value;
  logic             frame_end;
  logic             frame_incomplete;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  conv_scoreboard sb = new();
  bit             calm = 1'b0;     // suppress idling on both sides
  int unsigned    cycles = 0;
  int unsigned    requests = 0;

  separable_conv11_edge_clamp i_dut (
    .clk, .rst, .in_valid, .in_stall, .command, .pixel_value,
    .out_valid, .out_stall, .filtered_value, .frame_end, .frame_incomplete,
    .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stalls at random, sampled values are the pre-edge ones
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 33);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(filtered_value, frame_end, frame_incomplete);
  end

  // one request: random gaps first, then hold until accepted
  task automatic send(logic cmd, logic [PIX_W-1:0] pix);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    pixel_value <= pix;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, pix);
    requests++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    go_quiet();
    while (sb.pending_pixels.size() != 0) @(posedge clk);
  endtask

  // registers only change once the block is idle, incl. any row sweep
  task automatic write_dims(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    sb.set_reg(REG_WIDTH, w);
    @(negedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    sb.set_reg(REG_HEIGHT, h);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // fill: 0 random, 1 all max, 2 all zero; noisy adds early fetches and overflow loads
  task automatic run_frame(int fill, bit noisy);
    int unsigned total;
    logic [PIX_W-1:0] p;
    total = sb.cols() * sb.rows();
    for (int unsigned i = 0; i < total; i++) begin
      if (noisy && $urandom_range(99) < 5) send(CMD_FETCH, PIX_W'($urandom));
      p = (fill == 1) ? '1 : (fill == 2) ? '0 : PIX_W'($urandom);
      send(CMD_LOAD, p);
    end
    if (noisy) repeat ($urandom_range(3)) send(CMD_LOAD, PIX_W'($urandom));
    for (int unsigned i = 0; i < total; i++) send(CMD_FETCH, PIX_W'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fetches on an empty frame at reset size
    send(CMD_FETCH, '0);
    send(CMD_LOAD, 8'hff);
    send(CMD_LOAD, 8'h00);
    send(CMD_LOAD, 8'h5a);
    send(CMD_FETCH, '1);

    // both dimensions saturated high, frame left unfinished
    write_dims('1, '1);
    repeat (30) send(CMD_LOAD, PIX_W'($urandom));
    send(CMD_FETCH, '0);

    // narrow and tall from a saturated width, brightest image
    write_dims('0, 9'd20);
    run_frame(1, 1'b0);

    // wide and short from a saturated height, no idling on either side
    write_dims(9'd20, 9'd3);
    calm = 1'b1;
    run_frame(0, 1'b0);
    calm = 1'b0;

    // smallest frame, dark then random, then an abandoned partial frame
    write_dims(9'd11, 9'd11);
    run_frame(2, 1'b1);
    run_frame(0, 1'b1);
    repeat (40) send(CMD_LOAD, PIX_W'($urandom));
    send(CMD_FETCH, '0);

    // random small frames, some sizes below the minimum
    repeat (2) begin
      write_dims(CFG_W'($urandom_range(6, 16)), CFG_W'($urandom_range(6, 16)));
      run_frame(0, 1'b1);
    end

    drain();
    repeat (100) @(posedge clk);
    $display("%0d requests, %0d results, %0d frames read out, %0d early fetches",
             requests, sb.results, sb.frames, sb.early_fetches);
    $display("sizes 11x20, 20x11, 11x11 and small random ones, saturation at both ends");
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
